### sv/cubical_coface_enumerator_2d_defines.svh
// Assertion macros for the cubical coface enumerator.
`ifndef CUBICAL_COFACE_ENUMERATOR_2D_DEFINES_SVH
`define CUBICAL_COFACE_ENUMERATOR_2D_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a consequent in the same cycle as its antecedent.
`define CCFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CCFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CCFE_ASSERT_NOW(label, ante, cons, msg)
`define CCFE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### sv/ccfe_pkg.sv
// Shared types, codes and constants of the cubical coface enumerator.
package ccfe_pkg;

    // Default grid size and fixed field widths
    localparam int GRID_X_DEF  = 256;
    localparam int GRID_Y_DEF  = 256;
    localparam int VAL_W       = 32;
    localparam int COORD_W     = 8;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 56;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    // Register map
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic signed [VAL_W-1:0] THRESH_RESET = 32'sh7fff_ffff;

    // Item codes
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_ENUM  = 1'b1;
    localparam logic DIM_VERTEX = 1'b0;
    localparam logic DIM_EDGE   = 1'b1;
    localparam logic DIR_X      = 1'b0;
    localparam logic DIR_Y      = 1'b1;
    localparam logic [1:0] COF_EDGE   = 2'd1;
    localparam logic [1:0] COF_SQUARE = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_QUOT,
        S_MOD,
        S_ADDR,
        S_READ,
        S_CMP,
        S_WRITE,
        S_EVAL,
        S_FLUSH
    } state_t;

    // Control of the shared max unit
    typedef struct packed {
        logic en;
        logic first;
    } max_ctrl_t;

endpackage

### sv/ccfe_coord_mod.sv
// Two-stage reduction of a coordinate modulo a constant grid size.
module ccfe_coord_mod #(
    parameter int MODULUS = 256,
    parameter int OUT_W   = 8
) (
    input  logic                        aclk,
    input  logic [ccfe_pkg::COORD_W-1:0] raw,
    output logic [OUT_W-1:0]            rem_reg
);

    localparam int SHIFT   = 16;
    localparam int RECIP_W = 17;
    localparam int PROD_W  = ccfe_pkg::COORD_W + RECIP_W;
    localparam int DIFF_W  = 24;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << SHIFT) / MODULUS);

    logic [PROD_W-1:0]            prod;
    logic [ccfe_pkg::COORD_W-1:0] quot_next;
    logic [ccfe_pkg::COORD_W-1:0] quot_reg;
    logic [ccfe_pkg::COORD_W-1:0] raw_reg;
    logic [DIFF_W-1:0]            back;
    logic [DIFF_W-1:0]            diff;
    logic [DIFF_W-1:0]            rem_next;

    // Estimate the quotient by reciprocal multiply; it is low by at most one
    always_comb begin
        prod      = PROD_W'(raw) * PROD_W'(RECIP);
        quot_next = ccfe_pkg::COORD_W'(prod >> SHIFT);
    end

    // Subtract the multiple and correct once
    always_comb begin
        back     = DIFF_W'(quot_reg) * DIFF_W'(MODULUS);
        diff     = DIFF_W'(raw_reg) - back;
        rem_next = (diff >= DIFF_W'(MODULUS)) ? (diff - DIFF_W'(MODULUS)) : diff;
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        raw_reg  <= raw;
        rem_reg  <= OUT_W'(rem_next);
    end

endmodule

### sv/ccfe_pixel_mem.sv
// Single-port pixel store with registered read data.
module ccfe_pixel_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [DW-1:0] wdata,
    output logic [DW-1:0] rdata_reg
);

    logic [DW-1:0] mem [DEPTH];

    // Write on request, read every cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

endmodule

### sv/ccfe_max_unit.sv
// Shared signed max unit that folds pixel values into a coface birth.
module ccfe_max_unit (
    input  logic                                 aclk,
    input  ccfe_pkg::max_ctrl_t                  ctl,
    input  logic signed [ccfe_pkg::VAL_W-1:0]    cell_birth,
    input  logic signed [ccfe_pkg::VAL_W-1:0]    pix,
    input  logic signed [ccfe_pkg::VAL_W-1:0]    threshold,
    output logic signed [ccfe_pkg::VAL_W-1:0]    acc_reg,
    output logic                                 skip
);

    logic signed [ccfe_pkg::VAL_W-1:0] opa;
    logic signed [ccfe_pkg::VAL_W-1:0] acc_next;

    // Start from the cell birth on the first pixel of a coface
    always_comb begin
        opa      = ctl.first ? cell_birth : acc_reg;
        acc_next = (opa > pix) ? opa : pix;
    end

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            acc_reg <= acc_next;
        end
    end

    // Drop cofaces born at the threshold
    assign skip = (acc_reg == threshold);

endmodule

### sv/cubical_coface_enumerator_2d.sv
// Top level of the 2-D cubical coface enumerator.
//
//  channel | direction | contents
//  s_      | in        | load pixel or enumerate cell, kind in s_tuser
//  m_      | out       | one coface item, found in m_tuser, end of cell in m_tlast
//  apb     | in/out    | threshold register at byte address 0
//
// A load item passes the quot, mod, addr and write states from accept to ready again.
// An enumerate item for a vertex or an edge also waits while the result side stalls;
// each pixel goes through address, memory read and max compare on the single memory
// port and shared max unit.
// Reset is synchronous active low; the pixel store is not cleared.
// Back-pressure on m_ holds the sequencer whenever a coface must move to a still-full output.
`include "cubical_coface_enumerator_2d_defines.svh"

module cubical_coface_enumerator_2d #(
    parameter int GRID_X = ccfe_pkg::GRID_X_DEF,
    parameter int GRID_Y = ccfe_pkg::GRID_Y_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // x_coord[7:0], y_coord[15:8], pixel_value[47:16], cell_dim[48],
    // cell_dir[49], cell_birth[81:50], zero pad[87:82]
    input  logic [ccfe_pkg::IN_TDATA_W-1:0]      s_tdata,
    // kind[0]
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // coface_x[7:0], coface_y[15:8], coface_dir[16], coface_dim[18:17],
    // coface_birth[50:19], zero pad[55:51]
    output logic [ccfe_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // found[0]
    output logic                                 m_tuser,
    output logic                                 m_tlast,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [ccfe_pkg::APB_AW-1:0]          paddr,
    input  logic [ccfe_pkg::APB_DW-1:0]          pwdata,
    output logic [ccfe_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);

    localparam int XW    = $clog2(GRID_X);
    localparam int YW    = $clog2(GRID_Y);
    localparam int DEPTH = GRID_X * GRID_Y;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = ccfe_pkg::VAL_W;
    localparam int CW    = ccfe_pkg::COORD_W;

    ccfe_pkg::state_t state_reg, state_next;

    // Captured item
    logic                 kind_reg;
    logic [CW-1:0]        x_raw_reg;
    logic [CW-1:0]        y_raw_reg;
    logic signed [VW-1:0] pixel_reg;
    logic                 dim_reg;
    logic                 dir_reg;
    logic signed [VW-1:0] birth_reg;

    // Configuration
    logic signed [VW-1:0] thresh_reg;
    logic                 cfg_wr;

    // Reduced coordinates and neighbors
    logic [XW-1:0] x_cur, xp, xm, rd_x, em_x;
    logic [YW-1:0] y_cur, yp, ym, rd_y, em_y;
    logic          em_dir;
    logic [1:0]    em_dim;

    // Sequencer counters and controls
    logic [1:0]          k_reg;
    logic                r_reg;
    logic                read_last;
    logic                cof_last;
    logic                cap_en;
    logic                addr_en;
    logic                mem_we;
    logic                eval_go;
    logic                push_out;
    logic                out_free;
    ccfe_pkg::max_ctrl_t max_ctl;

    // Memory and max unit
    logic [AW-1:0]        addr_reg;
    logic [AW-1:0]        addr_next;
    logic [VW-1:0]        rdata;
    logic signed [VW-1:0] acc;
    logic                 skip;

    // Pending coface, held until the next one shows whether it is the last
    logic                 pend_valid_reg;
    logic [CW-1:0]        pend_x_reg;
    logic [CW-1:0]        pend_y_reg;
    logic                 pend_dir_reg;
    logic [1:0]           pend_dim_reg;
    logic signed [VW-1:0] pend_birth_reg;

    // Output register
    logic                 m_tvalid_reg;
    logic [CW-1:0]        out_x_reg;
    logic [CW-1:0]        out_y_reg;
    logic                 out_dir_reg;
    logic [1:0]           out_dim_reg;
    logic signed [VW-1:0] out_birth_reg;
    logic                 out_found_reg;
    logic                 out_last_reg;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[ccfe_pkg::APB_AW-1:2] == ccfe_pkg::REG_THRESHOLD);
    assign prdata = (paddr[ccfe_pkg::APB_AW-1:2] == ccfe_pkg::REG_THRESHOLD) ?
                    thresh_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg <= ccfe_pkg::THRESH_RESET;
        end else if (cfg_wr) begin
            thresh_reg <= pwdata;
        end
    end

    // Capture the item on accept
    always_ff @(posedge aclk) begin
        if (cap_en) begin
            kind_reg  <= s_tuser;
            x_raw_reg <= s_tdata[7:0];
            y_raw_reg <= s_tdata[15:8];
            pixel_reg <= s_tdata[47:16];
            dim_reg   <= s_tdata[48];
            dir_reg   <= s_tdata[49];
            birth_reg <= s_tdata[81:50];
        end
    end

    // Reduce positions into the grid
    ccfe_coord_mod #(.MODULUS(GRID_X), .OUT_W(XW)) u_mod_x (
        .aclk    (aclk),
        .raw     (x_raw_reg),
        .rem_reg (x_cur)
    );

    ccfe_coord_mod #(.MODULUS(GRID_Y), .OUT_W(YW)) u_mod_y (
        .aclk    (aclk),
        .raw     (y_raw_reg),
        .rem_reg (y_cur)
    );

    // Wrap neighbors around the grid
    always_comb begin
        xp = (x_cur == XW'(GRID_X - 1)) ? '0 : x_cur + XW'(1);
        xm = (x_cur == '0) ? XW'(GRID_X - 1) : x_cur - XW'(1);
        yp = (y_cur == YW'(GRID_Y - 1)) ? '0 : y_cur + YW'(1);
        ym = (y_cur == '0) ? YW'(GRID_Y - 1) : y_cur - YW'(1);
    end

    // Select the pixel to read and the coface position for this step
    always_comb begin
        rd_x   = x_cur;
        rd_y   = y_cur;
        em_x   = x_cur;
        em_y   = y_cur;
        em_dir = ccfe_pkg::DIR_X;
        em_dim = ccfe_pkg::COF_EDGE;
        if (kind_reg == ccfe_pkg::KIND_ENUM) begin
            if (dim_reg == ccfe_pkg::DIM_VERTEX) begin
                // edges in order y+, y-, x+, x-
                case (k_reg)
                    2'd0: begin
                        rd_y   = yp;
                        em_dir = ccfe_pkg::DIR_Y;
                    end
                    2'd1: begin
                        rd_y   = ym;
                        em_y   = ym;
                        em_dir = ccfe_pkg::DIR_Y;
                    end
                    2'd2: begin
                        rd_x = xp;
                    end
                    default: begin
                        rd_x = xm;
                        em_x = xm;
                    end
                endcase
            end else begin
                em_dim = ccfe_pkg::COF_SQUARE;
                if (dir_reg == ccfe_pkg::DIR_X) begin
                    // upper square, then lower
                    rd_y = k_reg[0] ? ym : yp;
                    rd_x = r_reg ? xp : x_cur;
                    em_y = k_reg[0] ? ym : y_cur;
                end else begin
                    // right square, then left
                    rd_x = k_reg[0] ? xm : xp;
                    rd_y = r_reg ? yp : y_cur;
                    em_x = k_reg[0] ? xm : x_cur;
                end
            end
        end
    end

    assign addr_next = AW'(rd_y) * AW'(GRID_X) + AW'(rd_x);

    always_ff @(posedge aclk) begin
        if (addr_en) begin
            addr_reg <= addr_next;
        end
    end

    ccfe_pixel_mem #(.DEPTH(DEPTH), .AW(AW), .DW(VW)) u_mem (
        .aclk      (aclk),
        .we        (mem_we),
        .addr      (addr_reg),
        .wdata     (pixel_reg),
        .rdata_reg (rdata)
    );

    ccfe_max_unit u_max (
        .aclk       (aclk),
        .ctl        (max_ctl),
        .cell_birth (birth_reg),
        .pix        (rdata),
        .threshold  (thresh_reg),
        .acc_reg    (acc),
        .skip       (skip)
    );

    // Step limits
    assign read_last = (dim_reg == ccfe_pkg::DIM_VERTEX) || r_reg;
    assign cof_last  = (dim_reg == ccfe_pkg::DIM_EDGE) ? (k_reg == 2'd1) : (k_reg == 2'd3);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ccfe_pkg::S_IDLE:  if (s_tvalid) state_next = ccfe_pkg::S_QUOT;
            ccfe_pkg::S_QUOT:  state_next = ccfe_pkg::S_MOD;
            ccfe_pkg::S_MOD:   state_next = ccfe_pkg::S_ADDR;
            ccfe_pkg::S_ADDR:  state_next = (kind_reg == ccfe_pkg::KIND_LOAD) ?
                                            ccfe_pkg::S_WRITE : ccfe_pkg::S_READ;
            ccfe_pkg::S_WRITE: state_next = ccfe_pkg::S_IDLE;
            ccfe_pkg::S_READ:  state_next = ccfe_pkg::S_CMP;
            ccfe_pkg::S_CMP:   state_next = read_last ? ccfe_pkg::S_EVAL : ccfe_pkg::S_ADDR;
            ccfe_pkg::S_EVAL: begin
                if (eval_go) begin
                    state_next = cof_last ? ccfe_pkg::S_FLUSH : ccfe_pkg::S_ADDR;
                end
            end
            ccfe_pkg::S_FLUSH: if (out_free) state_next = ccfe_pkg::S_IDLE;
            default:           state_next = ccfe_pkg::S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready = 1'b0;
        addr_en  = 1'b0;
        mem_we   = 1'b0;
        eval_go  = 1'b0;
        push_out = 1'b0;
        max_ctl  = '0;
        unique case (state_reg)
            ccfe_pkg::S_IDLE:  s_tready = 1'b1;
            ccfe_pkg::S_ADDR:  addr_en  = 1'b1;
            ccfe_pkg::S_WRITE: mem_we   = 1'b1;
            ccfe_pkg::S_CMP: begin
                max_ctl.en    = 1'b1;
                max_ctl.first = !r_reg;
            end
            ccfe_pkg::S_EVAL: begin
                // hold while a second coface waits on a full output
                if (skip || !pend_valid_reg || out_free) begin
                    eval_go  = 1'b1;
                    push_out = !skip && pend_valid_reg;
                end
            end
            ccfe_pkg::S_FLUSH: push_out = out_free;
            default: ;
        endcase
    end

    assign cap_en = s_tvalid && s_tready;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ccfe_pkg::S_IDLE;
            k_reg          <= '0;
            r_reg          <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cap_en) begin
                k_reg          <= '0;
                r_reg          <= 1'b0;
                pend_valid_reg <= 1'b0;
            end else if (state_reg == ccfe_pkg::S_CMP && !read_last) begin
                r_reg <= 1'b1;
            end else if (eval_go) begin
                r_reg <= 1'b0;
                k_reg <= k_reg + 2'd1;
                if (!skip) begin
                    pend_valid_reg <= 1'b1;
                end
            end
            if (push_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Pending coface payload
    always_ff @(posedge aclk) begin
        if (eval_go && !skip) begin
            pend_x_reg     <= CW'(em_x);
            pend_y_reg     <= CW'(em_y);
            pend_dir_reg   <= em_dir;
            pend_dim_reg   <= em_dim;
            pend_birth_reg <= acc;
        end
    end

    // Output payload: pending coface, or an empty marker when none was found
    always_ff @(posedge aclk) begin
        if (push_out) begin
            out_last_reg <= (state_reg == ccfe_pkg::S_FLUSH);
            if (pend_valid_reg) begin
                out_x_reg     <= pend_x_reg;
                out_y_reg     <= pend_y_reg;
                out_dir_reg   <= pend_dir_reg;
                out_dim_reg   <= pend_dim_reg;
                out_birth_reg <= pend_birth_reg;
                out_found_reg <= 1'b1;
            end else begin
                out_x_reg     <= '0;
                out_y_reg     <= '0;
                out_dir_reg   <= 1'b0;
                out_dim_reg   <= '0;
                out_birth_reg <= '0;
                out_found_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, out_birth_reg, out_dim_reg, out_dir_reg, out_y_reg, out_x_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `CCFE_ASSERT_NOW(a_push_into_free, push_out, !m_tvalid_reg || m_tready, "output item overwritten")
    `CCFE_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready while busy")
    `CCFE_ASSERT_NOW(a_empty_is_last, m_tvalid && !m_tuser, m_tlast, "empty result not last")
    `CCFE_ASSERT_NOW(a_write_on_load, mem_we, kind_reg == ccfe_pkg::KIND_LOAD, "store write on enumerate")

endmodule

### sim/cubical_coface_enumerator_2d_tb.sv
// Self-checking testbench for the 2-D cubical coface enumerator: load and enumerate items.
module cubical_coface_enumerator_2d_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WD_LIMIT   = 4000;  // cycles without any handshake
    localparam int SETTLE_CYC = 30;    // covers a trailing load or enumeration

    // One input item, unpacked to its fields
    typedef struct packed {
        logic        kind;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [31:0] pix_val;
        logic        dim;
        logic        dir;
        logic [31:0] birth;
    } cell_req_t;

    // One result item
    typedef struct packed {
        logic [7:0]  cx;
        logic [7:0]  cy;
        logic        cdir;
        logic [1:0]  cdim;
        logic [31:0] cbirth;
        logic        found;
        logic        is_last;
    } coface_t;

    logic                             aclk     = 1'b0;
    logic                             aresetn  = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [ccfe_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                             s_tuser  = 1'b0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [ccfe_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             m_tuser;
    logic                             m_tlast;
    logic                             psel     = 1'b0;
    logic                             penable  = 1'b0;
    logic                             pwrite   = 1'b0;
    logic [ccfe_pkg::APB_AW-1:0]      paddr    = '0;
    logic [ccfe_pkg::APB_DW-1:0]      pwdata   = '0;
    logic [ccfe_pkg::APB_DW-1:0]      prdata;
    logic                             pready;

    // Shadow of the block: pixel store and threshold register
    logic [31:0] pixel_mem [0:65535];
    logic [31:0] thr_value = ccfe_pkg::THRESH_RESET;

    // Pixels already loaded, tracked while items are generated
    bit          written_map [0:65535];

    cell_req_t   req_q[$];
    coface_t     coface_q[$];
    cell_req_t   cur_req, nxt_req;
    coface_t     got_cof, want_cof;

    int unsigned err_cnt = 0;
    int unsigned items_pushed = 0;
    int unsigned n_loads = 0, n_vertex = 0, n_edge = 0;
    int unsigned n_cofaces = 0, n_empty = 0;
    int unsigned idle_cycles = 0;

    bit          allow_idle = 1'b1;
    int unsigned gap_cnt = 0, send_left = 0;
    bit          send_gappy = 1'b0;
    int unsigned stall_cnt = 0, recv_left = 0;
    bit          recv_gappy = 1'b0;

    cubical_coface_enumerator_2d u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic [31:0] smax(input logic [31:0] a, input logic [31:0] b);
        return ($signed(a) > $signed(b)) ? a : b;
    endfunction

    function automatic logic [31:0] pix(input logic [7:0] px, input logic [7:0] py);
        return pixel_mem[{py, px}];
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // Queue one coface unless its birth sits at the threshold
    function automatic int add_coface(input int n, input logic [7:0] cx, input logic [7:0] cy,
                                      input logic cdir, input logic [1:0] cdim,
                                      input logic [31:0] cb);
        coface_t c;
        if (cb == thr_value)
            return n;
        c.cx      = cx;
        c.cy      = cy;
        c.cdir    = cdir;
        c.cdim    = cdim;
        c.cbirth  = cb;
        c.found   = 1'b1;
        c.is_last = 1'b0;
        coface_q.push_back(c);
        return n + 1;
    endfunction

    // Update the shadow store, or queue the cofaces an enumerate item yields
    function automatic void apply_item(input cell_req_t r);
        logic [7:0]  xp, xm, yp, ym;
        logic [31:0] b;
        int          n;
        coface_t     none;
        xp = r.x + 8'd1;
        xm = r.x - 8'd1;
        yp = r.y + 8'd1;
        ym = r.y - 8'd1;
        b  = r.birth;
        n  = 0;
        if (r.kind == ccfe_pkg::KIND_LOAD) begin
            pixel_mem[{r.y, r.x}] = r.pix_val;
            return;
        end
        if (r.dim == ccfe_pkg::DIM_VERTEX) begin
            n = add_coface(n, r.x, r.y, ccfe_pkg::DIR_Y, ccfe_pkg::COF_EDGE,
                           smax(b, pix(r.x, yp)));
            n = add_coface(n, r.x, ym, ccfe_pkg::DIR_Y, ccfe_pkg::COF_EDGE,
                           smax(b, pix(r.x, ym)));
            n = add_coface(n, r.x, r.y, ccfe_pkg::DIR_X, ccfe_pkg::COF_EDGE,
                           smax(b, pix(xp, r.y)));
            n = add_coface(n, xm, r.y, ccfe_pkg::DIR_X, ccfe_pkg::COF_EDGE,
                           smax(b, pix(xm, r.y)));
        end else if (r.dir == ccfe_pkg::DIR_X) begin
            // squares carry direction 0
            n = add_coface(n, r.x, r.y, ccfe_pkg::DIR_X, ccfe_pkg::COF_SQUARE,
                           smax(b, smax(pix(r.x, yp), pix(xp, yp))));
            n = add_coface(n, r.x, ym, ccfe_pkg::DIR_X, ccfe_pkg::COF_SQUARE,
                           smax(b, smax(pix(r.x, ym), pix(xp, ym))));
        end else begin
            n = add_coface(n, r.x, r.y, ccfe_pkg::DIR_X, ccfe_pkg::COF_SQUARE,
                           smax(b, smax(pix(xp, r.y), pix(xp, yp))));
            n = add_coface(n, xm, r.y, ccfe_pkg::DIR_X, ccfe_pkg::COF_SQUARE,
                           smax(b, smax(pix(xm, r.y), pix(xm, yp))));
        end
        if (n == 0) begin
            none         = '0;
            none.is_last = 1'b1;
            coface_q.push_back(none);
        end else begin
            coface_q[coface_q.size()-1].is_last = 1'b1;
        end
    endfunction

    // Driver: present queued items, predict each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_cnt  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_item(cur_req);
                if (cur_req.kind == ccfe_pkg::KIND_LOAD)
                    n_loads++;
                else if (cur_req.dim == ccfe_pkg::DIM_VERTEX)
                    n_vertex++;
                else
                    n_edge++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_cnt != 0) begin
                    gap_cnt  <= gap_cnt - 1;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() != 0) begin
                    nxt_req = req_q.pop_front();
                    cur_req  <= nxt_req;
                    s_tdata  <= {6'd0, nxt_req.birth, nxt_req.dir, nxt_req.dim,
                                 nxt_req.pix_val, nxt_req.y, nxt_req.x};
                    s_tuser  <= nxt_req.kind;
                    s_tvalid <= 1'b1;
                    // alternate stretches with and without gaps
                    if (send_left == 0) begin
                        send_left  <= $urandom_range(8, 40);
                        send_gappy <= 1'($urandom_range(0, 1));
                    end else begin
                        send_left <= send_left - 1;
                    end
                    if (allow_idle && send_gappy && $urandom_range(0, 2) == 0)
                        gap_cnt <= $urandom_range(1, 5);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result, stall the result side in bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_cof.cx      = m_tdata[7:0];
                got_cof.cy      = m_tdata[15:8];
                got_cof.cdir    = m_tdata[16];
                got_cof.cdim    = m_tdata[18:17];
                got_cof.cbirth  = m_tdata[50:19];
                got_cof.found   = m_tuser;
                got_cof.is_last = m_tlast;
                if (got_cof.found)
                    n_cofaces++;
                else
                    n_empty++;
                if (coface_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected item, expected none, got x=%0d y=%0d dim=%0d",
                             $time, got_cof.cx, got_cof.cy, got_cof.cdim);
                    $display("    birth=0x%0h found=%0b last=%0b",
                             got_cof.cbirth, got_cof.found, got_cof.is_last);
                end else begin
                    want_cof = coface_q.pop_front();
                    check_field("coface_x", want_cof.cx, got_cof.cx);
                    check_field("coface_y", want_cof.cy, got_cof.cy);
                    check_field("coface_dir", want_cof.cdir, got_cof.cdir);
                    check_field("coface_dim", want_cof.cdim, got_cof.cdim);
                    check_field("coface_birth", want_cof.cbirth, got_cof.cbirth);
                    check_field("found", want_cof.found, got_cof.found);
                    check_field("last", want_cof.is_last, got_cof.is_last);
                end
            end
            if (recv_left == 0) begin
                recv_left  <= $urandom_range(8, 60);
                recv_gappy <= 1'($urandom_range(0, 1));
            end else begin
                recv_left <= recv_left - 1;
            end
            if (stall_cnt != 0) begin
                stall_cnt <= stall_cnt - 1;
                m_tready  <= 1'b0;
            end else if (allow_idle && recv_gappy && $urandom_range(0, 3) == 0) begin
                stall_cnt <= $urandom_range(0, 4);
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when no handshake happens for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WD_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, WD_LIMIT, coface_q.size());
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return thr_value;
            1:       return thr_value - 32'd1;
            2:       return 32'h8000_0000;
            3:       return 32'h7fff_ffff;
            4:       return 32'h0;
            5, 6:    return 32'($urandom_range(0, 16)) - 32'd8;
            default: return $urandom();
        endcase
    endfunction

    // Favor the grid corners so that neighbors wrap often
    function automatic logic [7:0] pick_coord();
        case ($urandom_range(0, 3))
            0, 1:    return 8'($urandom_range(0, 7));
            2:       return 8'($urandom_range(248, 255));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_load(input logic [7:0] px, input logic [7:0] py,
                             input logic [31:0] v);
        cell_req_t r;
        r.kind    = ccfe_pkg::KIND_LOAD;
        r.x       = px;
        r.y       = py;
        r.pix_val = v;
        r.dim     = 1'($urandom_range(0, 1));
        r.dir     = 1'($urandom_range(0, 1));
        r.birth   = $urandom();
        written_map[{py, px}] = 1'b1;
        req_q.push_back(r);
        items_pushed++;
    endtask

    // Load any missing neighbor pixel first, then queue the enumeration
    task automatic push_enum(input logic [7:0] px, input logic [7:0] py, input logic dim,
                             input logic dir, input logic [31:0] b);
        logic [7:0] nx [4];
        logic [7:0] ny [4];
        cell_req_t  r;
        if (dim == ccfe_pkg::DIM_VERTEX) begin
            nx[0] = px;      ny[0] = py + 8'd1;
            nx[1] = px;      ny[1] = py - 8'd1;
            nx[2] = px + 8'd1; ny[2] = py;
            nx[3] = px - 8'd1; ny[3] = py;
        end else if (dir == ccfe_pkg::DIR_X) begin
            nx[0] = px;      ny[0] = py + 8'd1;
            nx[1] = px + 8'd1; ny[1] = py + 8'd1;
            nx[2] = px;      ny[2] = py - 8'd1;
            nx[3] = px + 8'd1; ny[3] = py - 8'd1;
        end else begin
            nx[0] = px + 8'd1; ny[0] = py;
            nx[1] = px + 8'd1; ny[1] = py + 8'd1;
            nx[2] = px - 8'd1; ny[2] = py;
            nx[3] = px - 8'd1; ny[3] = py + 8'd1;
        end
        for (int i = 0; i < 4; i++)
            if (!written_map[{ny[i], nx[i]}])
                push_load(nx[i], ny[i], pick_value());
        r.kind    = ccfe_pkg::KIND_ENUM;
        r.x       = px;
        r.y       = py;
        r.pix_val = $urandom();
        r.dim     = dim;
        r.dir     = dir;
        r.birth   = b;
        req_q.push_back(r);
        items_pushed++;
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned start;
        start = items_pushed;
        while (items_pushed - start < n) begin
            if ($urandom_range(0, 3) == 0)
                push_load(pick_coord(), pick_coord(), pick_value());
            else
                push_enum(pick_coord(), pick_coord(), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), pick_value());
        end
    endtask

    // Hold until every item is sent and every result has come back
    task automatic wait_drained();
        while (req_q.size() != 0 || s_tvalid || coface_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {ccfe_pkg::REG_THRESHOLD, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the threshold, then read it back
    task automatic write_threshold(input logic [31:0] v);
        apb_access(1'b1, v);
        thr_value = v;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {ccfe_pkg::REG_THRESHOLD, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        check_field("threshold readback", v, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part around the origin, threshold at its reset value
        push_load(0, 1, 32'h8000_0000);
        push_load(0, 255, 32'd7);
        push_load(1, 0, 32'h0);
        push_load(255, 0, 32'hffff_ffff);
        push_load(1, 1, 32'h7fff_ffff);
        push_load(1, 255, 32'd5);
        push_load(255, 1, 32'h0001_0000);
        // vertex with all its edges emitted, then one with every edge at the threshold
        push_enum(0, 0, ccfe_pkg::DIM_VERTEX, ccfe_pkg::DIR_X, 32'h8000_0000);
        push_enum(0, 0, ccfe_pkg::DIM_VERTEX, ccfe_pkg::DIR_Y, 32'h7fff_ffff);
        // x edge: upper square skipped, lower square still emitted; then both skipped
        push_enum(0, 0, ccfe_pkg::DIM_EDGE, ccfe_pkg::DIR_X, 32'h8000_0000);
        push_enum(0, 0, ccfe_pkg::DIM_EDGE, ccfe_pkg::DIR_X, 32'h7fff_ffff);
        // y edge: right square skipped, left square emitted
        push_enum(0, 0, ccfe_pkg::DIM_EDGE, ccfe_pkg::DIR_Y, 32'h7fff_fffe);
        push_enum(0, 0, ccfe_pkg::DIM_EDGE, ccfe_pkg::DIR_Y, 32'h0);
        // far corner, neighbors wrap to the low side
        push_enum(255, 255, ccfe_pkg::DIM_VERTEX, ccfe_pkg::DIR_X, 32'h0);
        push_enum(255, 255, ccfe_pkg::DIM_EDGE, ccfe_pkg::DIR_Y, 32'hffff_ffff);
        push_enum(255, 255, ccfe_pkg::DIM_EDGE, ccfe_pkg::DIR_X, 32'h8000_0000);
        // overwrite a pixel and look again
        push_load(1, 0, 32'h7fff_ffff);
        push_enum(0, 0, ccfe_pkg::DIM_VERTEX, ccfe_pkg::DIR_X, 32'h8000_0000);
        wait_drained();

        write_threshold(32'h8000_0000);
        run_random(100);
        wait_drained();

        write_threshold(32'h0);
        run_random(100);
        wait_drained();

        write_threshold($urandom());
        run_random(100);
        wait_drained();

        // last stretch at full rate on both sides
        allow_idle = 1'b0;
        write_threshold(ccfe_pkg::THRESH_RESET);
        run_random(100);
        wait_drained();

        $display("Run covered %0d loads, %0d vertex and %0d edge enumerations",
                 n_loads, n_vertex, n_edge);
        $display("under five threshold settings; %0d cofaces and %0d empty results checked",
                 n_cofaces, n_empty);
        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
